/* rtl/ffssc_pkg.sv */
// ----------------------------------------------------------------------------
// ffssc_pkg
// Shared types and constants for the fixed-length frame sync with additive
// checksum: frame geometry, register map and the sync phase encoding.
// ----------------------------------------------------------------------------
`default_nettype none

package ffssc_pkg;

  // Frame geometry: bytes per frame, header and checksum included.
  localparam int FrameBytes = 32;
  localparam int IdxW       = $clog2(FrameBytes);
  localparam int PosW       = 5;

  // Index of the checksum byte, which closes the frame.
  localparam logic [IdxW-1:0] LastIdx = IdxW'(FrameBytes - 1);

  // Register map of the configuration port.
  localparam int AddrW = 3;
  localparam int DataW = 32;

  typedef enum logic {
    REG_HEADER_FIRST  = 1'b0,
    REG_HEADER_SECOND = 1'b1
  } reg_idx_e;

  // Reset values of the header registers.
  localparam logic [7:0] HeaderFirstRst  = 8'hEE;
  localparam logic [7:0] HeaderSecondRst = 8'h16;

  // Sync phase: the unused code behaves as hunting.
  typedef enum logic [1:0] {
    PH_HUNT   = 2'd0,
    PH_SECOND = 2'd1,
    PH_BODY   = 2'd2
  } phase_e;

endpackage

`default_nettype wire

/* rtl/fixed_frame_sync_sum_check.sv */
// Flow: the accepted checksum byte of a passing frame starts the replay;
// each frame byte goes through one frame store read, then the output register
// load, and a further read waits until that byte is in the output register.
// Throughput: one received byte per cycle while collecting; input stalls
// while a validated frame is replayed, and the replay pauses while the output
// is stalled. Reset: hunting for the first header byte, headers 0xEE, 0x16.
// ----------------------------------------------------------------------------
// fixed_frame_sync_sum_check
// Hunts for a two-byte header in a byte stream, collects a fixed-length
// frame into a single-port-write frame store and checks the additive
// checksum; a passing frame is replayed byte by byte with a last marker.
// ----------------------------------------------------------------------------
`default_nettype none

module fixed_frame_sync_sum_check (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  // Received byte channel
  input  wire                          in_valid_i,
  output logic                         in_stall_o,
  input  wire  [7:0]                   rx_byte_i,
  // Frame byte channel
  output logic                         out_valid_o,
  input  wire                          out_stall_i,
  output logic [7:0]                   frame_byte_o,
  output logic [ffssc_pkg::PosW-1:0]   byte_position_o,
  output logic                         frame_last_o,
  // Configuration port
  input  wire                          psel,
  input  wire                          penable,
  input  wire                          pwrite,
  input  wire  [ffssc_pkg::AddrW-1:0]  paddr,
  input  wire  [ffssc_pkg::DataW-1:0]  pwdata,
  output logic [ffssc_pkg::DataW-1:0]  prdata,
  output logic                         pready
);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [7:0] hdr_first_q;
  logic [7:0] hdr_second_q;
  logic       cfg_wr;
  ffssc_pkg::reg_idx_e cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = ffssc_pkg::reg_idx_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_first_q  <= ffssc_pkg::HeaderFirstRst;
      hdr_second_q <= ffssc_pkg::HeaderSecondRst;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        ffssc_pkg::REG_HEADER_FIRST:  hdr_first_q  <= pwdata[7:0];
        ffssc_pkg::REG_HEADER_SECOND: hdr_second_q <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Read data follows the addressed register.
  always_comb begin
    unique case (cfg_idx)
      ffssc_pkg::REG_HEADER_FIRST:  prdata = {24'd0, hdr_first_q};
      ffssc_pkg::REG_HEADER_SECOND: prdata = {24'd0, hdr_second_q};
      default:                      prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sync state and replay control
  // --------------------------------------------------------------------------
  ffssc_pkg::phase_e            phase_q, phase_d;
  logic [ffssc_pkg::IdxW-1:0]   count_q, count_d;
  logic [7:0]                   sum_q, sum_d;
  logic                         replay_q, replay_d;
  logic [ffssc_pkg::IdxW-1:0]   rd_idx_q, rd_idx_d;
  logic                         pend_q;
  logic [ffssc_pkg::IdxW-1:0]   pend_idx_q;
  logic                         out_valid_q, out_valid_d;
  logic [7:0]                   out_byte_q;
  logic [ffssc_pkg::PosW-1:0]   out_pos_q;
  logic                         out_last_q;

  logic                         in_acc;
  logic                         out_free;
  logic                         rd_en;
  logic                         wr_en;
  logic [ffssc_pkg::IdxW-1:0]   wr_idx;
  logic [7:0]                   rd_data_q;

  assign in_stall_o = replay_q;
  assign in_acc     = in_valid_i && !replay_q;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign rd_en      = replay_q && !pend_q && out_free;

  // Next phase, count, sum and frame store write for one accepted byte, and the replay read index.
  always_comb begin
    phase_d  = phase_q;
    count_d  = count_q;
    sum_d    = sum_q;
    replay_d = replay_q;
    rd_idx_d = rd_idx_q;
    wr_en    = 1'b0;
    wr_idx   = count_q;

    if (in_acc) begin
      unique case (phase_q)
        ffssc_pkg::PH_SECOND: begin
          if (rx_byte_i == hdr_second_q) begin
            wr_en   = 1'b1;
            sum_d   = sum_q + rx_byte_i;
            count_d = count_q + 1'b1;
            phase_d = ffssc_pkg::PH_BODY;
          end else if (rx_byte_i == hdr_first_q) begin
            // A repeated first header byte restarts the header on itself.
            wr_en   = 1'b1;
            wr_idx  = '0;
            sum_d   = rx_byte_i;
            count_d = ffssc_pkg::IdxW'(1);
            phase_d = ffssc_pkg::PH_SECOND;
          end else begin
            sum_d   = '0;
            count_d = '0;
            phase_d = ffssc_pkg::PH_HUNT;
          end
        end
        ffssc_pkg::PH_BODY: begin
          if (count_q != ffssc_pkg::LastIdx) begin
            wr_en   = 1'b1;
            sum_d   = sum_q + rx_byte_i;
            count_d = count_q + 1'b1;
          end else begin
            // Checksum byte: keep it and replay on a match, else drop.
            if (rx_byte_i == sum_q) begin
              wr_en    = 1'b1;
              replay_d = 1'b1;
              rd_idx_d = '0;
            end
            sum_d   = '0;
            count_d = '0;
            phase_d = ffssc_pkg::PH_HUNT;
          end
        end
        default: begin
          if (rx_byte_i == hdr_first_q) begin
            wr_en   = 1'b1;
            wr_idx  = '0;
            sum_d   = rx_byte_i;
            count_d = ffssc_pkg::IdxW'(1);
            phase_d = ffssc_pkg::PH_SECOND;
          end else begin
            sum_d   = '0;
            count_d = '0;
            phase_d = ffssc_pkg::PH_HUNT;
          end
        end
      endcase
    end

    // Replay walks the store one read at a time.
    if (rd_en) begin
      if (rd_idx_q == ffssc_pkg::LastIdx) begin
        replay_d = 1'b0;
      end else begin
        rd_idx_d = rd_idx_q + 1'b1;
      end
    end
  end

  // Output register loads when read data returns, empties when taken.
  always_comb begin
    out_valid_d = out_valid_q;
    if (pend_q) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= ffssc_pkg::PH_HUNT;
      count_q     <= '0;
      sum_q       <= '0;
      replay_q    <= 1'b0;
      rd_idx_q    <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      count_q     <= count_d;
      sum_q       <= sum_d;
      replay_q    <= replay_d;
      rd_idx_q    <= rd_idx_d;
      pend_q      <= rd_en;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers of the read pipeline and the output stage.
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      pend_idx_q <= rd_idx_q;
    end
    if (pend_q) begin
      out_byte_q <= rd_data_q;
      out_pos_q  <= ffssc_pkg::PosW'(pend_idx_q);
      out_last_q <= (pend_idx_q == ffssc_pkg::LastIdx);
    end
  end

  // --------------------------------------------------------------------------
  // Frame store: one write port, one registered read port
  // --------------------------------------------------------------------------
  logic [7:0] frame_mem [ffssc_pkg::FrameBytes];

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      frame_mem[wr_idx] <= rx_byte_i;
    end
    if (rd_en) begin
      rd_data_q <= frame_mem[rd_idx_q];
    end
  end

  assign out_valid_o     = out_valid_q;
  assign frame_byte_o    = out_byte_q;
  assign byte_position_o = out_pos_q;
  assign frame_last_o    = out_last_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // Returning read data never overwrites a byte still waiting at the output.
  a_out_free_on_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> $past(out_free))
    else $error("read data returned while output register was busy");

  // A replay starts only from the checksum byte of a collected frame.
  a_replay_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(replay_q) |-> $past(phase_q == ffssc_pkg::PH_BODY &&
                              count_q == ffssc_pkg::LastIdx))
    else $error("replay started outside a frame's checksum byte");

  // After the checksum byte the sync logic is back to hunting.
  a_replay_hunt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(replay_q) |-> (phase_q == ffssc_pkg::PH_HUNT && count_q == '0))
    else $error("sync state not restarted after checksum byte");

  // The last marker only ever sits on the checksum byte position.
  a_last_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_last_q) |->
      (out_pos_q == ffssc_pkg::PosW'(ffssc_pkg::LastIdx)))
    else $error("last marker on a byte other than the checksum");

  // Hunting holds no bytes.
  a_hunt_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == ffssc_pkg::PH_HUNT) |-> (count_q == '0 && sum_q == '0))
    else $error("byte count or sum not clear while hunting");

endmodule

`default_nettype wire

/* test/fixed_frame_sync_sum_check_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_frame_sync_sum_check_test
// Drives received bytes into the frame sync block and checks every replayed
// frame byte against a local predictor of the header hunt and the additive
// checksum. A short directed table runs first, then random streams of mostly
// well-formed frames under several header settings, with random idling on
// both channels and one long hold-off on the output.
// ----------------------------------------------------------------------------

module fixed_frame_sync_sum_check_test;

  // One expected frame byte.
  typedef struct packed {
    logic [7:0]                 data;
    logic [ffssc_pkg::PosW-1:0] pos;
    logic                       last;
  } frame_res_t;

  // One row of the directed table; typed rows carry a result count to match.
  typedef struct packed {
    logic [7:0] rx;
    logic       typed;
    logic [5:0] n_res;
  } dir_row_t;

  localparam int DirRows  = 25;
  localparam int HoldLen  = 300;
  localparam int IdlePct  = 13;
  localparam int MaxLines = 30;

  logic                        clk_i;
  logic                        rst_ni          = 1'b0;
  logic                        in_valid_i      = 1'b0;
  logic [7:0]                  rx_byte_i       = 8'h00;
  logic                        out_stall_i     = 1'b0;
  logic                        psel            = 1'b0;
  logic                        penable         = 1'b0;
  logic                        pwrite          = 1'b0;
  logic [ffssc_pkg::AddrW-1:0] paddr           = '0;
  logic [ffssc_pkg::DataW-1:0] pwdata          = '0;
  wire                         in_stall_o;
  wire                         out_valid_o;
  wire  [7:0]                  frame_byte_o;
  wire  [ffssc_pkg::PosW-1:0]  byte_position_o;
  wire                         frame_last_o;
  wire  [ffssc_pkg::DataW-1:0] prdata;
  wire                         pready;

  fixed_frame_sync_sum_check uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .rx_byte_i       (rx_byte_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .frame_byte_o    (frame_byte_o),
    .byte_position_o (byte_position_o),
    .frame_last_o    (frame_last_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  // Predictor state: headers, sync phase, bytes held, sum and frame copy.
  logic [7:0]        hdr_a    = ffssc_pkg::HeaderFirstRst;
  logic [7:0]        hdr_b    = ffssc_pkg::HeaderSecondRst;
  ffssc_pkg::phase_e ph       = ffssc_pkg::PH_HUNT;
  int                held_cnt = 0;
  logic [7:0]        held_sum = 8'h00;
  logic [7:0]        frame_mem [ffssc_pkg::FrameBytes];
  frame_res_t        frame_q [$];

  int  last_n     = 0;
  int  sent_cnt   = 0;
  int  seen_cnt   = 0;
  int  frames_ok  = 0;
  int  errors     = 0;
  bit  calm       = 1'b0;
  bit  hold_armed = 1'b0;
  int  hold_left  = 0;

  dir_row_t dir_tab [DirRows] = '{
    '{8'hFF, 1'b1, 6'd0}, '{8'h00, 1'b1, 6'd0}, '{8'h16, 1'b1, 6'd0},
    '{8'hEE, 1'b1, 6'd0}, '{8'h00, 1'b1, 6'd0}, '{8'hEE, 1'b1, 6'd0},
    '{8'hEE, 1'b1, 6'd0}, '{8'h16, 1'b1, 6'd0},
    '{8'hFF, 1'b0, 6'd0}, '{8'h00, 1'b0, 6'd0}, '{8'h80, 1'b0, 6'd0},
    '{8'h7F, 1'b0, 6'd0}, '{8'h01, 1'b0, 6'd0}, '{8'hFE, 1'b0, 6'd0},
    '{8'h55, 1'b0, 6'd0}, '{8'hAA, 1'b0, 6'd0}, '{8'hEE, 1'b0, 6'd0},
    '{8'h16, 1'b0, 6'd0}, '{8'hEE, 1'b0, 6'd0}, '{8'h16, 1'b0, 6'd0},
    '{8'h0F, 1'b0, 6'd0}, '{8'hF0, 1'b0, 6'd0}, '{8'hC3, 1'b0, 6'd0},
    '{8'h3C, 1'b0, 6'd0}, '{8'h00, 1'b0, 6'd0}
  };

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs.
  initial begin
    #1_000_000;
    $display("timeout: %0d frame bytes still expected", frame_q.size());
    $display("status: fail");
    $finish;
  end

  // Print one mismatch line (up to a cap) and count it.
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    errors++;
    if (errors <= MaxLines)
      $display("mismatch: %s got 0x%0h expected 0x%0h", what, got, want);
  endtask

  // Drop any partial frame and go back to hunting.
  function automatic void restart_search();
    ph       = ffssc_pkg::PH_HUNT;
    held_cnt = 0;
    held_sum = 8'h00;
  endfunction

  // Hold one byte of the current frame and add it to the sum.
  function automatic void keep_byte(input logic [7:0] b);
    if (held_cnt < ffssc_pkg::FrameBytes) frame_mem[ffssc_pkg::IdxW'(held_cnt)] = b;
    held_sum = held_sum + b;
    held_cnt++;
  endfunction

  // Advance the predictor by one accepted byte and queue any frame it closes.
  function automatic void absorb_byte(input logic [7:0] b);
    frame_res_t r;
    last_n = 0;
    case (ph)
      ffssc_pkg::PH_SECOND: begin
        if (b == hdr_b) begin
          keep_byte(b);
          ph = ffssc_pkg::PH_BODY;
        end else if (b == hdr_a) begin
          restart_search();
          keep_byte(b);
          ph = ffssc_pkg::PH_SECOND;
        end else begin
          restart_search();
        end
      end
      ffssc_pkg::PH_BODY: begin
        if (held_cnt + 1 < ffssc_pkg::FrameBytes) begin
          keep_byte(b);
        end else begin
          if (b == held_sum) begin
            frame_mem[ffssc_pkg::LastIdx] = b;
            for (int k = 0; k < ffssc_pkg::FrameBytes; k++) begin
              r.data = frame_mem[ffssc_pkg::IdxW'(k)];
              r.pos  = ffssc_pkg::PosW'(k);
              r.last = (k == ffssc_pkg::FrameBytes - 1);
              frame_q.insert(frame_q.size(), r);
            end
            last_n = ffssc_pkg::FrameBytes;
          end
          restart_search();
        end
      end
      default: begin
        restart_search();
        if (b == hdr_a) begin
          keep_byte(b);
          ph = ffssc_pkg::PH_SECOND;
        end
      end
    endcase
  endfunction

  // Offer one byte, wait for the request to be taken, then predict.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = (!calm && $urandom_range(0, 99) < IdlePct) ? $urandom_range(1, 3) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    sent_cnt++;
    absorb_byte(b);
  endtask

  // Stop offering, let all expected bytes come out, then let the pipe settle.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (frame_q.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  // Write one header register over APB, then read it back.
  task automatic write_header(input ffssc_pkg::reg_idx_e idx, input logic [7:0] val);
    logic [ffssc_pkg::DataW-1:0] rd;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ffssc_pkg::AddrW'(4 * int'(idx));
    pwdata  <= ffssc_pkg::DataW'(val);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    case (idx)
      ffssc_pkg::REG_HEADER_FIRST:  hdr_a = val;
      ffssc_pkg::REG_HEADER_SECOND: hdr_b = val;
      default: ;
    endcase
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd[7:0] !== val) report_mismatch("header readback", rd, 32'(val));
  endtask

  // Send one frame from wherever the hunt stands; good or broken checksum.
  task automatic send_frame(input bit good);
    logic [7:0] b;
    while (ph != ffssc_pkg::PH_BODY) send_byte(ph == ffssc_pkg::PH_SECOND ? hdr_b : hdr_a);
    while (held_cnt < ffssc_pkg::FrameBytes - 1) begin
      case ($urandom_range(0, 6))
        0:       b = 8'h00;
        1:       b = 8'hFF;
        default: b = 8'($urandom_range(0, 255));
      endcase
      send_byte(b);
    end
    send_byte(good ? held_sum : held_sum ^ 8'($urandom_range(1, 255)));
  endtask

  // Random mix: mostly good frames, some bad checksums, noise, broken headers.
  task automatic run_mix(input int n_items);
    int start;
    int pick;
    int cnt;
    logic [7:0] b;
    start = sent_cnt;
    while (sent_cnt - start < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        send_frame(1'b1);
      end else if (pick < 70) begin
        send_frame(1'b0);
      end else if (pick < 85) begin
        cnt = $urandom_range(1, 5);
        repeat (cnt) begin
          case ($urandom_range(0, 3))
            0:       b = hdr_a;
            1:       b = hdr_b;
            default: b = 8'($urandom_range(0, 255));
          endcase
          send_byte(b);
        end
      end else begin
        send_byte(hdr_a);
        do b = 8'($urandom_range(0, 255)); while (b == hdr_b);
        send_byte(b);
      end
    end
  endtask

  // Output side: check each accepted frame byte and drive the stall.
  always @(posedge clk_i) begin : out_side
    frame_res_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        seen_cnt++;
        if (frame_q.size() == 0) begin
          report_mismatch("unexpected frame byte", 32'(frame_byte_o), 32'd0);
        end else begin
          want = frame_q.pop_front();
          if (frame_byte_o !== want.data)
            report_mismatch("frame_byte", 32'(frame_byte_o), 32'(want.data));
          if (byte_position_o !== want.pos)
            report_mismatch("byte_position", 32'(byte_position_o), 32'(want.pos));
          if (frame_last_o !== want.last)
            report_mismatch("frame_last", 32'(frame_last_o), 32'(want.last));
          if (want.last) frames_ok++;
        end
      end
      // A long hold-off starts on the first frame byte after arming.
      if (hold_armed && out_valid_o) begin
        hold_armed = 1'b0;
        hold_left  = HoldLen;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= !calm && ($urandom_range(0, 99) < IdlePct);
      end
    end
  end

  // Main sequence.
  initial begin : main_seq
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table under the reset headers.
    for (int i = 0; i < DirRows; i++) begin
      send_byte(dir_tab[i].rx);
      if (dir_tab[i].typed && last_n != int'(dir_tab[i].n_res))
        report_mismatch("directed result count", last_n, 32'(dir_tab[i].n_res));
    end

    // Change both headers in the middle of a frame, then close that frame.
    drain();
    write_header(ffssc_pkg::REG_HEADER_FIRST, 8'h00);
    write_header(ffssc_pkg::REG_HEADER_SECOND, 8'hFF);
    send_frame(1'b1);
    run_mix(90);

    // Swapped extremes, with no idling on either side.
    drain();
    write_header(ffssc_pkg::REG_HEADER_FIRST, 8'hFF);
    write_header(ffssc_pkg::REG_HEADER_SECOND, 8'h00);
    calm = 1'b1;
    run_mix(80);
    calm = 1'b0;

    // Both header bytes equal.
    drain();
    write_header(ffssc_pkg::REG_HEADER_FIRST, 8'h5A);
    write_header(ffssc_pkg::REG_HEADER_SECOND, 8'h5A);
    run_mix(80);

    // Back to reset headers; hold the output off while frames keep coming.
    drain();
    write_header(ffssc_pkg::REG_HEADER_FIRST, ffssc_pkg::HeaderFirstRst);
    write_header(ffssc_pkg::REG_HEADER_SECOND, ffssc_pkg::HeaderSecondRst);
    hold_armed = 1'b1;
    send_frame(1'b1);
    send_frame(1'b1);

    // Random headers to finish.
    drain();
    write_header(ffssc_pkg::REG_HEADER_FIRST, 8'($urandom_range(0, 255)));
    write_header(ffssc_pkg::REG_HEADER_SECOND, 8'($urandom_range(0, 255)));
    run_mix(60);
    drain();

    $display("summary: %0d bytes sent, %0d frame bytes checked, %0d frames replayed",
             sent_cnt, seen_cnt, frames_ok);
    $display("summary: header pairs reset, extremes, equal, random; one long output hold");
    if (errors == 0 && frame_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
